>>> rtl/fpksc_pkg.sv
package fpksc_pkg;

  localparam int KEY_W   = 8;
  localparam int TICK_W  = 32;
  localparam int HOLD_W  = 16;
  localparam int FREQ_W  = 20;
  localparam int MENU_W  = 2;
  localparam int WAVE_W  = 3;
  localparam int VPP_W   = 6;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // register word index, taken from paddr[3:2]
  localparam logic [1:0] REG_HOLD_TIME   = 2'd0;
  localparam logic [1:0] REG_TAP_CEIL    = 2'd1;
  localparam logic [1:0] REG_REPEAT_CEIL = 2'd2;

  localparam logic [KEY_W-1:0] KEY_ENABLE = 8'd1;
  localparam logic [KEY_W-1:0] KEY_MENU   = 8'd2;
  localparam logic [KEY_W-1:0] KEY_UP     = 8'd3;
  localparam logic [KEY_W-1:0] KEY_DEC    = 8'd4;

  localparam logic [MENU_W-1:0] MENU_WAVE = 2'd0;
  localparam logic [MENU_W-1:0] MENU_FREQ = 2'd1;
  localparam logic [MENU_W-1:0] MENU_VPP  = 2'd2;
  localparam logic [MENU_W-1:0] MENU_LAST = 2'd2;

  localparam logic [WAVE_W-1:0] WAVE_FIRST = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_LAST  = 3'd4;

  localparam logic [VPP_W-1:0] VPP_MIN = 6'd15;
  localparam logic [VPP_W-1:0] VPP_MAX = 6'd33;

  localparam logic [HOLD_W-1:0] HOLD_TIME_RST   = 16'd1000;
  localparam logic [FREQ_W-1:0] TAP_CEIL_RST    = 20'd100000;
  localparam logic [FREQ_W-1:0] REPEAT_CEIL_RST = 20'd1000000;
  localparam logic [FREQ_W-1:0] FREQ_RST        = 20'd1000;

  typedef struct packed {
    logic              key_pressed_pulse;
    logic              output_enabled;
    logic              output_off_pulse;
    logic              table_update_pulse;
    logic              freq_update_pulse;
    logic              vpp_update_pulse;
    logic              send_allow_pulse;
    logic [MENU_W-1:0] menu_index;
    logic [WAVE_W-1:0] wave_mode;
    logic [FREQ_W-1:0] frequency;
    logic [VPP_W-1:0]  vpp_tenths;
  } result_t;

endpackage

>>> rtl/fpksc_if.sv
interface fpksc_scan_if import fpksc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_code;
  logic [TICK_W-1:0] now_tick;

  modport source (output valid, key_code, now_tick, input ready);
  modport sink   (input valid, key_code, now_tick, output ready);
endinterface

interface fpksc_result_if import fpksc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              key_pressed_pulse;
  logic              output_enabled;
  logic              output_off_pulse;
  logic              table_update_pulse;
  logic              freq_update_pulse;
  logic              vpp_update_pulse;
  logic              send_allow_pulse;
  logic [MENU_W-1:0] menu_index;
  logic [WAVE_W-1:0] wave_mode;
  logic [FREQ_W-1:0] frequency;
  logic [VPP_W-1:0]  vpp_tenths;

  modport source (
    output valid, key_pressed_pulse, output_enabled, output_off_pulse,
           table_update_pulse, freq_update_pulse, vpp_update_pulse,
           send_allow_pulse, menu_index, wave_mode, frequency, vpp_tenths,
    input  ready
  );
  modport sink (
    input  valid, key_pressed_pulse, output_enabled, output_off_pulse,
           table_update_pulse, freq_update_pulse, vpp_update_pulse,
           send_allow_pulse, menu_index, wave_mode, frequency, vpp_tenths,
    output ready
  );
endinterface

>>> rtl/front_panel_key_settings_controller_core.sv
// Front-panel key settings controller.
// scan_i carries one key scan per beat: key code and the free-running tick.
// result_o returns exactly one beat per scan: event pulses for the beeper,
// display, wave table, frequency/amplitude updaters and host report, plus
// the current settings (enable, menu index, wave mode, frequency, Vpp).
// The APB port writes hold time and the two frequency ceilings; change
// them only while no scan is in flight. pready is tied high.
// Latency: the result beat is valid in the cycle after the scan is taken.
// Throughput: one scan per cycle; edge detect, deadline add/compare and
// setting steps are a single combinational pass into the result register.
// scan_i.ready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result beat
// and blocks new scans only until it is taken.
// Reset: enable off, menu 0, sine wave, 1000 Hz, 3.3 Vpp, no key held,
// hold time 1000 ticks, ceilings 100000 and 1000000; result register empty.
module front_panel_key_settings_controller_core import fpksc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fpksc_scan_if.sink            scan_i,
  fpksc_result_if.source        result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [HOLD_W-1:0] hold_time_q;
  logic [FREQ_W-1:0] tap_ceil_q;
  logic [FREQ_W-1:0] repeat_ceil_q;

  logic [KEY_W-1:0]  prev_key_q;
  logic [TICK_W-1:0] deadline_q, deadline_d;
  logic              enable_q, enable_d;
  logic [MENU_W-1:0] menu_q, menu_d;
  logic [WAVE_W-1:0] wave_q, wave_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic [VPP_W-1:0]  vpp_q, vpp_d;

  logic              out_valid_q;
  result_t           res_q, res_d;

  logic              accept;
  logic [KEY_W-1:0]  diff, down, up;
  logic              hold_live;
  logic              up_step, key_step;
  logic              step_inc;
  logic [FREQ_W-1:0] ceil_sel;
  logic [FREQ_W:0]   freq_inc;
  logic [FREQ_W-1:0] freq_dec;
  logic [VPP_W:0]    vpp_sum;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_HOLD_TIME:   prdata = APB_DATA_W'(hold_time_q);
      REG_TAP_CEIL:    prdata = APB_DATA_W'(tap_ceil_q);
      REG_REPEAT_CEIL: prdata = APB_DATA_W'(repeat_ceil_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q   <= HOLD_TIME_RST;
      tap_ceil_q    <= TAP_CEIL_RST;
      repeat_ceil_q <= REPEAT_CEIL_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HOLD_TIME:   hold_time_q   <= pwdata[HOLD_W-1:0];
        REG_TAP_CEIL:    tap_ceil_q    <= pwdata[FREQ_W-1:0];
        REG_REPEAT_CEIL: repeat_ceil_q <= pwdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- scan processing ----------------
  assign scan_i.ready = !out_valid_q || result_o.ready;
  assign accept       = scan_i.valid && scan_i.ready;

  assign diff = scan_i.key_code ^ prev_key_q;
  assign down = scan_i.key_code & diff;
  assign up   = ~scan_i.key_code & diff;

  // a fresh key-down re-arms the deadline before the compare
  assign deadline_d = (down != '0) ? scan_i.now_tick + TICK_W'(hold_time_q) : deadline_q;
  assign hold_live  = deadline_d > scan_i.now_tick;

  assign up_step  = hold_live && (up == KEY_UP || up == KEY_DEC);
  assign key_step = !hold_live && (scan_i.key_code == KEY_UP || scan_i.key_code == KEY_DEC);
  assign step_inc = hold_live ? (up == KEY_UP) : (scan_i.key_code == KEY_UP);
  assign ceil_sel = hold_live ? tap_ceil_q : repeat_ceil_q;

  always_comb begin
    freq_inc = {1'b0, freq_q};
    if (freq_q < 20'd10)         freq_inc = {1'b0, freq_q} + 21'd1;
    else if (freq_q < 20'd100)   freq_inc = {1'b0, freq_q} + 21'd10;
    else if (freq_q < 20'd1000)  freq_inc = {1'b0, freq_q} + 21'd100;
    else if (freq_q < ceil_sel)  freq_inc = {1'b0, freq_q} + 21'd1000;
  end

  always_comb begin
    freq_dec = freq_q;
    if (freq_q > 20'd1000)     freq_dec = freq_q - 20'd1000;
    else if (freq_q > 20'd100) freq_dec = freq_q - 20'd100;
    else if (freq_q > 20'd10)  freq_dec = freq_q - 20'd10;
    else if (freq_q > 20'd1)   freq_dec = freq_q - 20'd1;
  end

  assign vpp_sum = step_inc ? {1'b0, vpp_q} + 7'd2 : {1'b0, vpp_q} - 7'd2;

  always_comb begin
    enable_d = enable_q;
    menu_d   = menu_q;
    wave_d   = wave_q;
    freq_d   = freq_q;
    vpp_d    = vpp_q;
    res_d    = '0;

    res_d.key_pressed_pulse = (down != '0);

    if (hold_live && up == KEY_ENABLE) begin
      enable_d                 = !enable_q;
      res_d.table_update_pulse = !enable_q;
      res_d.output_off_pulse   = enable_q;
    end else if (hold_live && up == KEY_MENU) begin
      menu_d = (menu_q >= MENU_LAST) ? MENU_WAVE : menu_q + 2'd1;
    end else if (up_step || key_step) begin
      res_d.send_allow_pulse   = 1'b1;
      res_d.table_update_pulse = 1'b1;
      if (menu_q == MENU_FREQ) begin
        res_d.freq_update_pulse = 1'b1;
        if (step_inc) begin
          freq_d = freq_inc[FREQ_W] ? '1 : freq_inc[FREQ_W-1:0];
        end else begin
          freq_d = freq_dec;
        end
      end else if (up_step && menu_q == MENU_WAVE) begin
        if (step_inc) begin
          wave_d = (wave_q == WAVE_FIRST || wave_q == '0) ? WAVE_LAST : wave_q - 3'd1;
        end else begin
          wave_d = (wave_q >= WAVE_LAST) ? WAVE_FIRST : wave_q + 3'd1;
        end
      end else if (up_step && menu_q == MENU_VPP) begin
        res_d.vpp_update_pulse = 1'b1;
        if (step_inc) begin
          vpp_d = (vpp_sum >= 7'(VPP_MAX) + 7'd1) ? VPP_MAX : vpp_sum[VPP_W-1:0];
        end else begin
          vpp_d = (vpp_sum < 7'(VPP_MIN) || vpp_sum > 7'd63) ? VPP_MIN : vpp_sum[VPP_W-1:0];
        end
      end
    end

    res_d.output_enabled = enable_d;
    res_d.menu_index     = menu_d;
    res_d.wave_mode      = wave_d;
    res_d.frequency      = freq_d;
    res_d.vpp_tenths     = vpp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q <= '0;
      deadline_q <= '0;
      enable_q   <= 1'b0;
      menu_q     <= MENU_WAVE;
      wave_q     <= WAVE_FIRST;
      freq_q     <= FREQ_RST;
      vpp_q      <= VPP_MAX;
    end else if (accept) begin
      prev_key_q <= scan_i.key_code;
      deadline_q <= deadline_d;
      enable_q   <= enable_d;
      menu_q     <= menu_d;
      wave_q     <= wave_d;
      freq_q     <= freq_d;
      vpp_q      <= vpp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the payload while the beat is stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.key_pressed_pulse  = res_q.key_pressed_pulse;
  assign result_o.output_enabled     = res_q.output_enabled;
  assign result_o.output_off_pulse   = res_q.output_off_pulse;
  assign result_o.table_update_pulse = res_q.table_update_pulse;
  assign result_o.freq_update_pulse  = res_q.freq_update_pulse;
  assign result_o.vpp_update_pulse   = res_q.vpp_update_pulse;
  assign result_o.send_allow_pulse   = res_q.send_allow_pulse;
  assign result_o.menu_index         = res_q.menu_index;
  assign result_o.wave_mode          = res_q.wave_mode;
  assign result_o.frequency          = res_q.frequency;
  assign result_o.vpp_tenths         = res_q.vpp_tenths;

endmodule

>>> rtl/fpksc_checker.sv
module fpksc_checker import fpksc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              scan_valid,
  input logic              scan_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_enabled,
  input logic              res_off_pulse,
  input logic [MENU_W-1:0] res_menu,
  input logic [VPP_W-1:0]  res_vpp
);

  // every taken scan shows up as a result beat in the next cycle
  a_scan_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_valid && scan_ready |=> res_valid)
    else $error("taken scan gave no result beat");

  // an empty result register must never block the scan channel
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid |-> scan_ready)
    else $error("scan stalled with empty result register");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_vpp) && $stable(res_menu))
    else $error("stalled result beat changed");

  a_off_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_off_pulse |-> !res_enabled)
    else $error("off pulse with output still enabled");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_menu <= MENU_LAST && res_vpp >= VPP_MIN && res_vpp <= VPP_MAX)
    else $error("menu index or amplitude out of range");

endmodule

bind front_panel_key_settings_controller_core fpksc_checker u_fpksc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .scan_valid    (scan_i.valid),
  .scan_ready    (scan_i.ready),
  .res_valid     (result_o.valid),
  .res_ready     (result_o.ready),
  .res_enabled   (result_o.output_enabled),
  .res_off_pulse (result_o.output_off_pulse),
  .res_menu      (result_o.menu_index),
  .res_vpp       (result_o.vpp_tenths)
);

>>> tb/sv/front_panel_key_settings_controller_core_tb.sv
module front_panel_key_settings_controller_core_tb;
  import fpksc_pkg::*;

  localparam int RESET_CYCLES    = 9;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 116;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED     = 40;

  localparam logic [KEY_W-1:0]  KEY_NONE = 8'd0;
  localparam int unsigned       FREQ_TOP = (1 << FREQ_W) - 1;

  localparam int SEND_IDLE_PCT [4]  = '{0, 85, 0, 20};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 85, 20};

  class key_panel_tracker;
    logic [HOLD_W-1:0] hold_ticks;
    logic [FREQ_W-1:0] tap_ceil;
    logic [FREQ_W-1:0] repeat_ceil;
    logic [KEY_W-1:0]  last_key;
    logic [TICK_W-1:0] deadline;
    logic              enabled;
    logic [MENU_W-1:0] menu;
    logic [WAVE_W-1:0] wave;
    logic [FREQ_W-1:0] freq;
    logic [VPP_W-1:0]  vpp;
    result_t           due_results[$];
    int                errors;
    int                beats_seen;

    function new();
      hold_ticks  = HOLD_TIME_RST;
      tap_ceil    = TAP_CEIL_RST;
      repeat_ceil = REPEAT_CEIL_RST;
      last_key    = KEY_NONE;
      deadline    = '0;
      enabled     = 1'b0;
      menu        = MENU_WAVE;
      wave        = WAVE_FIRST;
      freq        = FREQ_RST;
      vpp         = VPP_MAX;
      errors      = 0;
      beats_seen  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_HOLD_TIME:   hold_ticks = value[HOLD_W-1:0];
        REG_TAP_CEIL:    tap_ceil = value[FREQ_W-1:0];
        REG_REPEAT_CEIL: repeat_ceil = value[FREQ_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // decade steps: +1 below 10, +10 below 100, +100 below 1000, then +1000 under the ceiling
    function logic [FREQ_W-1:0] freq_raised(logic [FREQ_W-1:0] ceil);
      int unsigned f;
      f = freq;
      if (f < 10) f += 1;
      else if (f < 100) f += 10;
      else if (f < 1000) f += 100;
      else if (f < ceil) f += 1000;
      if (f > FREQ_TOP) f = FREQ_TOP;
      return FREQ_W'(f);
    endfunction

    function logic [FREQ_W-1:0] freq_lowered();
      int unsigned f;
      f = freq;
      if (f > 1000) f -= 1000;
      else if (f > 100) f -= 100;
      else if (f > 10) f -= 10;
      else if (f > 1) f -= 1;
      return FREQ_W'(f);
    endfunction

    function void take_scan(logic [KEY_W-1:0] key, logic [TICK_W-1:0] now);
      logic [KEY_W-1:0]  diff;
      logic [KEY_W-1:0]  down;
      logic [KEY_W-1:0]  up;
      logic [WAVE_W-1:0] w;
      int                v;
      result_t           r;
      diff = key ^ last_key;
      down = key & diff;
      up = ~key & diff;
      r = '0;
      last_key = key;

      if (down != 0) begin
        r.key_pressed_pulse = 1'b1;
        deadline = now + TICK_W'(hold_ticks);
      end

      if (deadline > now) begin
        // short press: act on the released key only
        case (up)
          KEY_ENABLE: begin
            enabled = ~enabled;
            if (enabled) r.table_update_pulse = 1'b1;
            else r.output_off_pulse = 1'b1;
          end
          KEY_MENU: begin
            menu = (menu >= MENU_LAST) ? MENU_WAVE : menu + 1'b1;
          end
          KEY_UP, KEY_DEC: begin
            case (menu)
              MENU_WAVE: begin
                if (up == KEY_UP) begin
                  w = wave - 1'b1;
                  if (w == 0) w = WAVE_LAST;
                end else begin
                  w = wave + 1'b1;
                  if (w > WAVE_LAST || w == 0) w = WAVE_FIRST;
                end
                wave = w;
              end
              MENU_FREQ: begin
                freq = (up == KEY_UP) ? freq_raised(tap_ceil) : freq_lowered();
                r.freq_update_pulse = 1'b1;
              end
              MENU_VPP: begin
                v = vpp;
                if (up == KEY_UP) begin
                  v += 2;
                  if (v > VPP_MAX) v = VPP_MAX;
                end else begin
                  v -= 2;
                  if (v < VPP_MIN) v = VPP_MIN;
                end
                vpp = VPP_W'(v);
                r.vpp_update_pulse = 1'b1;
              end
              default: ;
            endcase
            r.send_allow_pulse = 1'b1;
            r.table_update_pulse = 1'b1;
          end
          default: ;
        endcase
      end else if (key == KEY_UP || key == KEY_DEC) begin
        // long press: auto-repeat frequency steps
        if (menu == MENU_FREQ) begin
          freq = (key == KEY_UP) ? freq_raised(repeat_ceil) : freq_lowered();
          r.freq_update_pulse = 1'b1;
        end
        r.send_allow_pulse = 1'b1;
        r.table_update_pulse = 1'b1;
      end

      r.output_enabled = enabled;
      r.menu_index = menu;
      r.wave_mode = wave;
      r.frequency = freq;
      r.vpp_tenths = vpp;
      due_results.push_back(r);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("ERROR beat %0d: %s", beats_seen, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_beat(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result beat with no scan waiting");
        return;
      end
      want = due_results.pop_front();
      check_field("key_pressed_pulse", got.key_pressed_pulse, want.key_pressed_pulse);
      check_field("output_enabled", got.output_enabled, want.output_enabled);
      check_field("output_off_pulse", got.output_off_pulse, want.output_off_pulse);
      check_field("table_update_pulse", got.table_update_pulse, want.table_update_pulse);
      check_field("freq_update_pulse", got.freq_update_pulse, want.freq_update_pulse);
      check_field("vpp_update_pulse", got.vpp_update_pulse, want.vpp_update_pulse);
      check_field("send_allow_pulse", got.send_allow_pulse, want.send_allow_pulse);
      check_field("menu_index", got.menu_index, want.menu_index);
      check_field("wave_mode", got.wave_mode, want.wave_mode);
      check_field("frequency", got.frequency, want.frequency);
      check_field("vpp_tenths", got.vpp_tenths, want.vpp_tenths);
      beats_seen++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fpksc_scan_if   scan_bus ();
  fpksc_result_if result_bus ();

  key_panel_tracker tracker = new();

  int                send_idle_pct   = 0;
  int                recv_stall_pct  = 0;
  int                hold_off_cycles = 0;
  int                items_sent      = 0;
  int unsigned       cycle_count     = 0;
  logic [TICK_W-1:0] tick;

  front_panel_key_settings_controller_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scan_i   (scan_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("front_panel_key_settings_controller_core: mismatch");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  always begin
    @(posedge clk_i);
    if (hold_off_cycles > 0) begin
      result_bus.ready <= 1'b0;
      repeat (hold_off_cycles) @(posedge clk_i);
      hold_off_cycles = 0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : beat_monitor
    result_t beat;
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        beat = '{result_bus.key_pressed_pulse, result_bus.output_enabled,
                 result_bus.output_off_pulse, result_bus.table_update_pulse,
                 result_bus.freq_update_pulse, result_bus.vpp_update_pulse,
                 result_bus.send_allow_pulse, result_bus.menu_index,
                 result_bus.wave_mode, result_bus.frequency, result_bus.vpp_tenths};
        tracker.check_beat(beat);
      end
      if (scan_bus.valid && scan_bus.ready)
        tracker.take_scan(scan_bus.key_code, scan_bus.now_tick);
    end
  end

  task automatic send_scan(input logic [KEY_W-1:0] key, input logic [TICK_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      scan_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    scan_bus.valid    <= 1'b1;
    scan_bus.key_code <= key;
    scan_bus.now_tick <= now;
    @(posedge clk_i);
    while (!scan_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid and hold until every pending result beat is back
  task automatic drain_results();
    scan_bus.valid <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int phase);
    logic [APB_DATA_W-1:0] hold;
    logic [APB_DATA_W-1:0] tap;
    logic [APB_DATA_W-1:0] rep;
    case (phase)
      0: begin hold = 20;    tap = TAP_CEIL_RST; rep = REPEAT_CEIL_RST; end
      1: begin hold = 0;     tap = 1;            rep = 1;               end
      2: begin hold = 65535; tap = 1000000;      rep = 1000000;         end
      3: begin hold = 3;     tap = 1000000;      rep = 1;               end
      default: begin
        hold = $urandom_range(60);
        tap  = $urandom_range(1000000, 1);
        rep  = $urandom_range(1000000, 1);
      end
    endcase
    write_register(REG_HOLD_TIME, hold);
    write_register(REG_TAP_CEIL, tap);
    write_register(REG_REPEAT_CEIL, rep);
  endtask

  // advance time so that roughly half the releases land before the deadline
  function automatic void step_tick();
    if ($urandom_range(99) < 4) tick = $urandom;
    else tick += $urandom_range(2 * tracker.hold_ticks + 2);
  endfunction

  task automatic run_random(input int count);
    int               stop_at;
    int               pick;
    logic [KEY_W-1:0] k;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      k = KEY_W'($urandom_range(KEY_DEC, KEY_ENABLE));
      if (pick < 75) begin
        // press, hold a few scans, release
        step_tick();
        send_scan(k, tick);
        repeat ($urandom_range(3)) begin
          step_tick();
          send_scan(k, tick);
        end
        step_tick();
        send_scan(KEY_NONE, tick);
      end else if (pick < 88) begin
        step_tick();
        send_scan(KEY_W'($urandom), tick);
      end else begin
        // overlapping keys without a clean release
        step_tick();
        send_scan(k, tick);
        step_tick();
        send_scan(KEY_W'($urandom_range(7)), tick);
      end
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    scan_bus.valid    <= 1'b0;
    scan_bus.key_code <= KEY_NONE;
    scan_bus.now_tick <= '0;
    result_bus.ready  <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, enable toggles, menu steps, short and long presses, wraps
    send_scan(KEY_NONE, 0);
    send_scan(KEY_ENABLE, 10);
    send_scan(KEY_NONE, 20);
    send_scan(KEY_ENABLE, 30);
    send_scan(KEY_NONE, 40);
    send_scan(KEY_MENU, 50);
    send_scan(KEY_NONE, 60);
    send_scan(KEY_UP, 70);
    send_scan(KEY_NONE, 80);
    send_scan(KEY_DEC, 2000);
    send_scan(KEY_DEC, 3100);
    send_scan(KEY_DEC, 3200);
    send_scan(KEY_NONE, 3300);
    send_scan(KEY_MENU, 3400);
    send_scan(KEY_NONE, 3410);
    send_scan(KEY_UP, 3420);
    send_scan(KEY_NONE, 3430);
    send_scan(KEY_MENU, 3440);
    send_scan(KEY_NONE, 3450);
    send_scan(KEY_UP, 3460);
    send_scan(KEY_NONE, 3470);
    send_scan(KEY_DEC, 3480);
    send_scan(KEY_NONE, 3490);
    send_scan(8'hFF, 32'hFFFF_FFFF);
    send_scan(KEY_NONE, 5);
    tick = 5;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      apply_settings(p);
      send_idle_pct  = SEND_IDLE_PCT[p % 4];
      recv_stall_pct = RECV_STALL_PCT[p % 4];
      if (p == 4) begin
        // fill the block while the receiver holds off
        hold_off_cycles = HOLD_OFF_CYCLES;
        run_random(16);
      end
      run_random(ITEMS_PER_PHASE);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("front_panel_key_settings_controller_core: match");
    end else begin
      $display("front_panel_key_settings_controller_core: mismatch");
    end
    $finish;
  end

endmodule
